// File: design/epwc_pkg.sv
// Package for the echo pulse width capture block.
// Holds the shared constants, register indexes and the capture result type.
// No dependencies; every other design file but epwc_in_if imports it.
package epwc_pkg;

    // Default counter width of the free-running tick counter.
    localparam int COUNTER_BITS_DEFAULT = 16;

    // Field widths of the items.
    localparam int PRESCALE_BITS = 16;
    localparam int TICKS_BITS    = 16;
    localparam int DIST_BITS     = 11;

    // Configuration port geometry.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_PRESCALE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE   = 1'd1;

    // Reset value of the prescale register.
    localparam logic [PRESCALE_BITS-1:0] PRESCALE_RESET = 16'd7;

    // Largest reported pulse length.
    localparam logic [TICKS_BITS-1:0] PULSE_MAX = 16'hFFFF;

    // Centimeters per tick: divide by 59 as a multiply by a rounded-up
    // reciprocal, 71090 = ceil(2^22 / 59), then a shift by 22. The rounding
    // error stays below one unit over the whole 16-bit input range.
    localparam int CM_DIVISOR      = 59;
    localparam int RECIP_SHIFT     = 22;
    localparam int RECIP_BITS      = 17;
    localparam logic [RECIP_BITS-1:0] CM_RECIP = 17'd71090;
    localparam int PRODUCT_BITS    = TICKS_BITS + RECIP_BITS;

    // What the capture unit reports for the item now being accepted.
    typedef struct packed {
        logic                  hit;
        logic [TICKS_BITS-1:0] ticks;
    } epwc_capture_t;

endpackage

// File: design/epwc_in_if.sv
// Input channel interface: one sampled echo pin level per item.
// Depends on nothing; used by the top level and the test environment.
interface epwc_in_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

// File: design/epwc_out_if.sv
// Result channel interface: one measured pulse and its distance per item.
// Depends on epwc_pkg for the field widths.
interface epwc_out_if
    import epwc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [TICKS_BITS-1:0] pulse_ticks;
    logic [DIST_BITS-1:0]  distance_cm;

    modport source (output valid, output pulse_ticks, output distance_cm, input ready);
    modport sink   (input valid, input pulse_ticks, input distance_cm, output ready);
endinterface

// File: design/epwc_capture.sv
// Capture unit: prescaler, free-running counter, edge detection and arming.
// Depends on epwc_pkg; instantiated by echo_pulse_width_capture.
module epwc_capture
    import epwc_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic                     level,
    input  logic [PRESCALE_BITS-1:0] prescale,
    input  logic                     enable,
    output epwc_capture_t            capture
);

    localparam int WIDE_BITS = (COUNTER_BITS > TICKS_BITS) ? COUNTER_BITS : TICKS_BITS;

    logic [PRESCALE_BITS-1:0] prescale_count_reg, prescale_count_next;
    logic [COUNTER_BITS-1:0]  count_value_reg, count_value_next;
    logic [COUNTER_BITS-1:0]  start_count_reg, start_count_next;
    logic                     armed_reg, armed_next;
    logic                     prior_level_reg;

    logic                     rising;
    logic                     falling;
    logic                     start_hit;
    logic                     end_hit;
    logic                     expire;
    logic [COUNTER_BITS-1:0]  length;
    logic [WIDE_BITS-1:0]     length_wide;

    // Edge detection against the level of the previous item.
    assign rising    = level & ~prior_level_reg;
    assign falling   = ~level & prior_level_reg;
    assign start_hit = enable & ~armed_reg & rising;
    assign end_hit   = enable & armed_reg & falling;
    assign expire    = (prescale_count_reg >= prescale);

    // Pulse length modulo the counter width, saturated to the result field.
    assign length      = count_value_reg - start_count_reg;
    assign length_wide = WIDE_BITS'(length);

    always_comb
    begin
        capture.hit = end_hit;
        if (length_wide > WIDE_BITS'(PULSE_MAX))
        begin
            capture.ticks = PULSE_MAX;
        end
        else
        begin
            capture.ticks = length_wide[TICKS_BITS-1:0];
        end
    end

    // Next state of the prescaler, counter and arming logic.
    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        count_value_next    = count_value_reg;
        start_count_next    = start_count_reg;
        armed_next          = armed_reg;
        if (enable)
        begin
            if (start_hit)
            begin
                start_count_next = count_value_reg;
                armed_next       = 1'b1;
            end
            else if (end_hit)
            begin
                armed_next = 1'b0;
            end

            if (expire)
            begin
                prescale_count_next = '0;
                if (!end_hit)
                begin
                    count_value_next = count_value_reg + 1'b1;
                end
            end
            else
            begin
                prescale_count_next = prescale_count_reg + 1'b1;
            end

            // The end of a pulse restarts the counter from zero.
            if (end_hit)
            begin
                count_value_next = '0;
            end
        end
    end

    // State registers advance once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            count_value_reg    <= '0;
            start_count_reg    <= '0;
            armed_reg          <= 1'b0;
            prior_level_reg    <= 1'b0;
        end
        else if (step)
        begin
            prescale_count_reg <= prescale_count_next;
            count_value_reg    <= count_value_next;
            start_count_reg    <= start_count_next;
            armed_reg          <= armed_next;
            prior_level_reg    <= level;
        end
    end

endmodule

// File: design/echo_pulse_width_capture.sv
// Echo pulse width capture for ultrasonic ranging. One echo pin sample is
// taken per item and an item is accepted every cycle, also while a finished
// result waits on the result channel; only a full pipeline under a stalled
// result channel holds the input back. A prescaler of prescale+1 items drives
// a COUNTER_BITS counter; a rising edge arms the unit, the following falling
// edge yields the pulse length and the distance in centimeters (length / 59)
// through the length register, then the reciprocal multiply into the result
// register. The user must write configuration through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block itself does not enforce it.
module echo_pulse_width_capture
    import epwc_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    epwc_in_if.sink                   echo,
    epwc_out_if.source                result,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic [PRESCALE_BITS-1:0] prescale_reg;
    logic                     enable_reg;

    logic                     accept;
    logic                     s1_ready;
    logic                     out_ready;
    epwc_capture_t            capture;

    logic                     s1_valid_reg;
    logic [TICKS_BITS-1:0]    s1_ticks_reg;
    logic                     out_valid_reg;
    logic [TICKS_BITS-1:0]    pulse_ticks_reg;
    logic [DIST_BITS-1:0]     distance_cm_reg;
    logic [PRODUCT_BITS-1:0]  product;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= PRESCALE_RESET;
            enable_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PRESCALE: prescale_reg <= cfg_data[PRESCALE_BITS-1:0];
                REG_ENABLE:   enable_reg   <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Handshake: each stage takes new data when it is empty or drains.
    assign out_ready    = ~out_valid_reg | result.ready;
    assign s1_ready     = ~s1_valid_reg | out_ready;
    assign echo.ready   = s1_ready;
    assign accept       = echo.valid & s1_ready;

    epwc_capture #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_capture (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (accept),
        .level    (echo.echo_level),
        .prescale (prescale_reg),
        .enable   (enable_reg),
        .capture  (capture)
    );

    // Length register: holds a finished measurement.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= accept & capture.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_ticks_reg <= capture.ticks;
        end
    end

    // Divide by 59 through the reciprocal multiply.
    assign product = PRODUCT_BITS'(s1_ticks_reg) * PRODUCT_BITS'(CM_RECIP);

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            pulse_ticks_reg <= s1_ticks_reg;
            distance_cm_reg <= product[RECIP_SHIFT +: DIST_BITS];
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.pulse_ticks = pulse_ticks_reg;
    assign result.distance_cm = distance_cm_reg;

endmodule

// File: design/epwc_checker.sv
// Port-level checker for echo_pulse_width_capture and its bind statement.
// Depends on epwc_pkg; attaches to the top level through bind.
module epwc_checker
    import epwc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  echo_valid,
    input logic                  echo_ready,
    input logic                  result_valid,
    input logic                  result_ready,
    input logic [TICKS_BITS-1:0] pulse_ticks,
    input logic [DIST_BITS-1:0]  distance_cm
);

    logic [PRODUCT_BITS-1:0] dist_low;

    assign dist_low = PRODUCT_BITS'(distance_cm) * PRODUCT_BITS'(CM_DIVISOR);

    // A stalled result item holds its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(pulse_ticks) && $stable(distance_cm))
        else $error("result item changed while stalled");

    // The distance is the pulse length divided by 59, truncated.
    a_distance: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            dist_low <= PRODUCT_BITS'(pulse_ticks) &&
            PRODUCT_BITS'(pulse_ticks) < dist_low + PRODUCT_BITS'(CM_DIVISOR))
        else $error("distance does not match pulse length");

    // A new result follows an accepted input item through the length and result registers.
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(echo_valid && echo_ready, 2))
        else $error("result item without a causing input item");

endmodule

bind echo_pulse_width_capture epwc_checker u_epwc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .echo_valid   (echo.valid),
    .echo_ready   (echo.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .pulse_ticks  (result.pulse_ticks),
    .distance_cm  (result.distance_cm)
);
